// ===== rtl/mpbc_pkg.sv =====
`default_nettype none

package mpbc_pkg;

    // Field widths
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ACT_W    = 6;
    localparam int MASK_W   = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BUTTONS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Result queue
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PW    = 2;
    localparam int OUTQ_CW    = 2;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             raw_level;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] report_index;
        logic [CNT_W-1:0] press_total;
    } out_item_t;

    // One stored entry per button
    typedef struct packed {
        logic [CNT_W-1:0] gap;
        logic [CNT_W-1:0] press;
    } entry_t;

    // Control from the update stage into the result queue
    typedef struct packed {
        logic      push;
        out_item_t item;
    } outq_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mpbc_ram.sv =====
`default_nettype none

module mpbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/mpbc_outq.sv =====
`default_nettype none

module mpbc_outq
    import mpbc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire outq_wr_t            wr,
    output logic [OUTQ_CW-1:0]       count,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_item_t                m_payload
);

    out_item_t              slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0]     cnt_reg, cnt_next;
    logic                   pop;

    assign pop       = m_valid && m_ready;
    assign m_valid   = (cnt_reg != '0);
    assign m_payload = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr.push) begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !wr.push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            slot_reg[wr_ptr_reg] <= wr.item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.push && cnt_reg == OUTQ_CW'(OUTQ_DEPTH) && !pop))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/multi_press_button_counter.sv =====
// Path: an accepted sample enters the stage 1 registers while its state word is read;
//   then stage 1 writes the update and queues any result for m_valid/m_payload.
// Throughput: one sample per cycle while s_ready is high; a same-button sample in the next
//   cycle is served by forwarding the last write, so there is no interlock stall.
// Stall: s_ready drops only while the 3-beat result queue plus the item in flight
//   could fill it; it is driven from flops.
// Reset (aresetn low, synchronous): config registers to 0, per-button valid bits
//   cleared at once so every entry reads as zero; no clearing pass.
`default_nettype none

module multi_press_button_counter
    import mpbc_pkg::*;
#(
    parameter int NUM_BUTTONS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_payload,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_payload,
    // configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Only 2**IDX_W buttons are addressable, whatever NUM_BUTTONS says.
    localparam int DEPTH = (NUM_BUTTONS < (1 << IDX_W)) ? NUM_BUTTONS : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = $bits(entry_t);

    // ---------------- configuration ----------------
    logic [ACT_W-1:0]  active_buttons_reg;
    logic [CNT_W-1:0]  max_gap_reg;
    logic [MASK_W-1:0] active_low_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_buttons_reg  <= '0;
            max_gap_reg         <= '0;
            active_low_mask_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ACTIVE_BUTTONS:  active_buttons_reg  <= cfg_data[ACT_W-1:0];
                REG_MAX_GAP:         max_gap_reg         <= cfg_data[CNT_W-1:0];
                REG_ACTIVE_LOW_MASK: active_low_mask_reg <= cfg_data[MASK_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- stage 0: accept, polarity, range, read ----------------
    logic              s_fire;
    logic              s0_in_range;
    logic              s0_pressed;
    logic [AW-1:0]     s0_addr;
    logic [OUTQ_CW-1:0] q_count;
    logic              s1_valid_reg, s1_valid_next;

    // Room check: queue occupancy plus one possible result still in stage 1.
    assign s_ready = ({1'b0, q_count} + {{OUTQ_CW{1'b0}}, s1_valid_reg})
                     < (OUTQ_CW + 1)'(OUTQ_DEPTH);
    assign s_fire  = s_valid && s_ready;

    assign s0_in_range = ({1'b0, s_payload.button_index} < active_buttons_reg)
                      && (32'(s_payload.button_index) < 32'(NUM_BUTTONS));
    // low-active bit flips the sense of the pin
    assign s0_pressed  = s_payload.raw_level ^ active_low_mask_reg[s_payload.button_index];
    assign s0_addr     = s_payload.button_index[AW-1:0];

    // ---------------- stage 1 registers ----------------
    logic [AW-1:0]     s1_addr_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_pressed_reg;

    // Out-of-range samples are consumed here and never reach stage 1.
    assign s1_valid_next = s_fire && s0_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_addr_reg    <= s0_addr;
            s1_idx_reg     <= s_payload.button_index;
            s1_pressed_reg <= s0_pressed;
        end
    end

    // ---------------- state memory ----------------
    logic [EW-1:0]     rd_data;
    entry_t            wr_entry;
    logic [DEPTH-1:0]  entry_valid_reg;

    mpbc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_entry),
        .rd_addr (s0_addr),
        .rd_data (rd_data)
    );

    // Entries not yet written read as zero (reset value).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (s1_valid_reg) begin
            entry_valid_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // Last write, held in registers: the RAM read issued on the same edge as that
    // write returns the old word, so a back-to-back hit takes this copy instead.
    logic              lw_valid_reg;
    logic [AW-1:0]     lw_addr_reg;
    entry_t            lw_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else begin
            lw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            lw_addr_reg  <= s1_addr_reg;
            lw_entry_reg <= wr_entry;
        end
    end

    // ---------------- stage 1: modify ----------------
    entry_t            cur;
    logic [CNT_W-1:0]  gap_step;
    logic              report;
    outq_wr_t          q_wr;

    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) begin
            cur = lw_entry_reg;
        end else if (entry_valid_reg[s1_addr_reg]) begin
            cur = entry_t'(rd_data);
        end else begin
            cur = '0;
        end

        wr_entry = cur;
        report   = 1'b0;
        gap_step = cur.gap;

        if (s1_pressed_reg && (cur.gap != '0)) begin
            // counted press: saturating count, gap restarts
            if (cur.press != CNT_MAX) begin
                wr_entry.press = cur.press + 1'b1;
            end
            wr_entry.gap = '0;
        end else begin
            // released sample extends the gap up to one past the timeout
            if (!s1_pressed_reg && (cur.gap <= max_gap_reg) && (cur.gap != CNT_MAX)) begin
                gap_step = cur.gap + 1'b1;
            end
            wr_entry.gap = gap_step;
            if ((gap_step > max_gap_reg) && (cur.press != '0)) begin
                report   = 1'b1;
                wr_entry = '0;
            end
        end

        q_wr.push              = s1_valid_reg && report;
        q_wr.item.report_index = s1_idx_reg;
        q_wr.item.press_total  = cur.press;
    end

    // ---------------- result queue ----------------
    mpbc_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (q_wr),
        .count     (q_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    a_total_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.press_total != '0))
        else $error("reported press total is zero");

    a_report_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_payload.report_index} < active_buttons_reg))
        else $error("report for inactive button");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |=> (lw_valid_reg && lw_entry_reg == '0))
        else $error("entry not cleared after report");
`endif

endmodule

`default_nettype wire
